[design/i2cms_pkg.sv]
package i2cms_pkg;

    // Default largest transfer, in bytes.
    localparam int MAX_BYTES_DEF = 8;

    // Bus status handling: low three bits carry no meaning.
    localparam logic [7:0] ST_MASK        = 8'hF8;
    localparam logic [7:0] ST_START_SENT  = 8'h08;
    localparam logic [7:0] ST_WR_ADDR_ACK = 8'h18;
    localparam logic [7:0] ST_WR_DATA_ACK = 8'h28;
    localparam logic [7:0] ST_RD_ADDR_ACK = 8'h40;
    localparam logic [7:0] ST_RD_DATA_ACK = 8'h50;
    localparam logic [7:0] ST_RD_DATA_NAK = 8'h58;

    // Request kinds.
    localparam logic REQ_SUBMIT = 1'b0;
    localparam logic REQ_EVENT  = 1'b1;

    // Commands to the bus engine.
    typedef enum logic [2:0] {
        CMD_NONE    = 3'd0,
        CMD_START   = 3'd1,
        CMD_SEND    = 3'd2,
        CMD_RX_ACK  = 3'd3,
        CMD_RX_NACK = 3'd4,
        CMD_STOP    = 3'd5,
        CMD_ABORT   = 3'd6
    } t_cmd;

    // Held phases of one transfer.
    typedef enum logic [5:0] {
        PH_IDLE         = 6'b000001,
        PH_START_WAIT   = 6'b000010,
        PH_RD_ADDR_WAIT = 6'b000100,
        PH_WR_ADDR_WAIT = 6'b001000,
        PH_RD_DATA_WAIT = 6'b010000,
        PH_WR_DATA_WAIT = 6'b100000
    } t_phase;

    // Phase numbers as reported on a failure.
    localparam logic [3:0] PN_IDLE         = 4'd0;
    localparam logic [3:0] PN_START_WAIT   = 4'd2;
    localparam logic [3:0] PN_RD_ADDR_WAIT = 4'd3;
    localparam logic [3:0] PN_WR_ADDR_WAIT = 4'd4;
    localparam logic [3:0] PN_RD_DATA_WAIT = 4'd7;
    localparam logic [3:0] PN_WR_DATA_WAIT = 4'd8;

    typedef struct packed {
        logic        req_type;
        logic [7:0]  slave_addr;
        logic [3:0]  byte_count;
        logic [63:0] write_bytes;
        logic [7:0]  bus_status;
        logic [7:0]  rx_byte;
    } t_in_item;

    typedef struct packed {
        t_cmd        bus_cmd;
        logic [7:0]  tx_byte;
        logic        done_res;
        logic [63:0] read_bytes;
        logic [3:0]  read_count;
        logic        failed;
        logic [3:0]  failed_phase;
        logic [7:0]  failed_status;
        logic        rejected;
    } t_result;

    function automatic logic [3:0] phase_num(input t_phase ph);
        logic [3:0] num;
        case (ph)
            PH_IDLE:         num = PN_IDLE;
            PH_START_WAIT:   num = PN_START_WAIT;
            PH_RD_ADDR_WAIT: num = PN_RD_ADDR_WAIT;
            PH_WR_ADDR_WAIT: num = PN_WR_ADDR_WAIT;
            PH_RD_DATA_WAIT: num = PN_RD_DATA_WAIT;
            PH_WR_DATA_WAIT: num = PN_WR_DATA_WAIT;
            default:         num = PN_IDLE;
        endcase
        return num;
    endfunction

endpackage

[design/i2cms_step.sv]
module i2cms_step #(
    parameter int MAX_BYTES = i2cms_pkg::MAX_BYTES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  i2cms_pkg::t_in_item i_item,
    output i2cms_pkg::t_result  o_res
);
    import i2cms_pkg::*;

    localparam int BUF_W = MAX_BYTES * 8;

    t_phase             r_phase, n_phase;
    logic [3:0]         r_idx, n_idx;
    logic [7:0]         r_addr, n_addr;
    logic [3:0]         r_len, n_len;
    logic [BUF_W-1:0]   r_buf, n_buf;

    logic [7:0] st;
    logic [3:0] cnt;
    logic [3:0] idx_new;
    logic [3:0] idx_inc;
    logic       last_rd;
    logic       status_ok;
    logic       go_next;
    logic       is_read;
    logic [7:0] sel_byte;
    t_result    res;

    assign st      = i_item.bus_status & ST_MASK;
    assign idx_inc = r_idx + 4'd1;
    assign last_rd = (idx_inc == r_len);

    // One step of the transfer sequence for the item at the head.
    always_comb begin
        n_phase   = r_phase;
        n_idx     = r_idx;
        n_addr    = r_addr;
        n_len     = r_len;
        n_buf     = r_buf;
        res       = '0;
        res.bus_cmd = CMD_NONE;
        cnt       = i_item.byte_count;
        idx_new   = r_idx;
        status_ok = 1'b0;
        go_next   = 1'b0;
        is_read   = 1'b0;
        sel_byte  = '0;

        if (i_item.req_type == REQ_SUBMIT) begin
            if (r_phase != PH_IDLE) begin
                res.rejected = 1'b1;
            end else begin
                if (cnt > 4'(MAX_BYTES)) begin
                    cnt = 4'(MAX_BYTES);
                end
                n_addr      = i_item.slave_addr;
                n_len       = cnt;
                n_idx       = '0;
                n_buf       = i_item.write_bytes[BUF_W-1:0];
                n_phase     = PH_START_WAIT;
                res.bus_cmd = CMD_START;
            end
        end else begin
            // Check the masked status against the code this phase expects.
            case (r_phase)
                PH_START_WAIT:   status_ok = (st == ST_START_SENT);
                PH_WR_ADDR_WAIT: status_ok = (st == ST_WR_ADDR_ACK);
                PH_WR_DATA_WAIT: status_ok = (st == ST_WR_DATA_ACK);
                PH_RD_ADDR_WAIT: status_ok = (st == ST_RD_ADDR_ACK);
                PH_RD_DATA_WAIT: status_ok = last_rd ? (st == ST_RD_DATA_NAK)
                                                     : (st == ST_RD_DATA_ACK);
                default:         status_ok = 1'b0;
            endcase

            if (!status_ok) begin
                res.bus_cmd       = CMD_ABORT;
                res.failed        = 1'b1;
                res.failed_phase  = phase_num(r_phase);
                res.failed_status = st;
                n_phase           = PH_IDLE;
            end else begin
                case (r_phase)
                    PH_START_WAIT: begin
                        res.bus_cmd = CMD_SEND;
                        res.tx_byte = r_addr;
                        n_phase     = r_addr[0] ? PH_RD_ADDR_WAIT : PH_WR_ADDR_WAIT;
                    end
                    PH_WR_ADDR_WAIT: begin
                        idx_new = '0;
                        go_next = 1'b1;
                    end
                    PH_WR_DATA_WAIT: begin
                        idx_new = idx_inc;
                        go_next = 1'b1;
                    end
                    PH_RD_ADDR_WAIT: begin
                        idx_new = '0;
                        go_next = 1'b1;
                        is_read = 1'b1;
                    end
                    PH_RD_DATA_WAIT: begin
                        for (int i = 0; i < MAX_BYTES; i++) begin
                            if (r_idx == 4'(i)) begin
                                n_buf[i*8 +: 8] = i_item.rx_byte;
                            end
                        end
                        idx_new = idx_inc;
                        go_next = 1'b1;
                        is_read = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end

            // Next data byte, next receive, or the closing stop.
            if (go_next) begin
                n_idx = idx_new;
                for (int i = 0; i < MAX_BYTES; i++) begin
                    if (idx_new == 4'(i)) begin
                        sel_byte = n_buf[i*8 +: 8];
                    end
                end
                if (idx_new >= r_len) begin
                    res.bus_cmd    = CMD_STOP;
                    res.done_res   = 1'b1;
                    res.read_count = r_len;
                    for (int i = 0; i < MAX_BYTES; i++) begin
                        if (4'(i) < r_len) begin
                            res.read_bytes[i*8 +: 8] = n_buf[i*8 +: 8];
                        end
                    end
                    n_phase = PH_IDLE;
                end else if (is_read) begin
                    res.bus_cmd = ((idx_new + 4'd1) == r_len) ? CMD_RX_NACK : CMD_RX_ACK;
                    n_phase     = PH_RD_DATA_WAIT;
                end else begin
                    res.bus_cmd = CMD_SEND;
                    res.tx_byte = sel_byte;
                    n_phase     = PH_WR_DATA_WAIT;
                end
            end
        end
    end

    assign o_res = res;

    // Sequencer state moves only when the item is handed on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_idx   <= '0;
            r_addr  <= '0;
            r_len   <= '0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
            r_addr  <= n_addr;
            r_len   <= n_len;
        end
    end

    // Data buffer holds no reset value.
    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_buf <= n_buf;
        end
    end

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= 4'(MAX_BYTES))
        else $error("transfer length above maximum");

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= r_len)
        else $error("byte index beyond transfer length");

    a_idle_after_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && (res.done_res || res.failed) |=> r_phase == PH_IDLE)
        else $error("sequencer not idle after stop or abort");

endmodule

[design/i2c_master_transaction_sequencer_top.sv]
// Channel | Valid      | Stall       | Payload
// input   | i_in_valid | o_in_stall  | i_req_type .. i_rx_byte
// result  | o_out_valid| i_out_stall | o_bus_cmd .. o_rejected
//
// One item per cycle is taken unless stalled; each item gives exactly one result.
// The rate is set by the single sequencer step between the input and result registers.
// Reset is synchronous and active low; it returns the sequencer to idle.
// A stalled result holds and pushes back on the input register, one item deep per stage.
module i2c_master_transaction_sequencer_top #(
    parameter int MAX_BYTES = i2cms_pkg::MAX_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_req_type,
    input  logic [7:0]  i_slave_addr,
    input  logic [3:0]  i_byte_count,
    input  logic [63:0] i_write_bytes,
    input  logic [7:0]  i_bus_status,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_bus_cmd,
    output logic [7:0]  o_tx_byte,
    output logic        o_done_res,
    output logic [63:0] o_read_bytes,
    output logic [3:0]  o_read_count,
    output logic        o_failed,
    output logic [3:0]  o_failed_phase,
    output logic [7:0]  o_failed_status,
    output logic        o_rejected
);
    import i2cms_pkg::*;

    logic     r_in_valid;
    t_in_item r_in;
    logic     r_out_valid;
    t_result  r_out;
    t_result  step_res;
    logic     out_free;
    logic     fire;
    logic     in_take;

    // Handshake between the two register stages.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    // Input item register.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in.req_type    <= i_req_type;
            r_in.slave_addr  <= i_slave_addr;
            r_in.byte_count  <= i_byte_count;
            r_in.write_bytes <= i_write_bytes;
            r_in.bus_status  <= i_bus_status;
            r_in.rx_byte     <= i_rx_byte;
        end
    end

    i2cms_step #(
        .MAX_BYTES (MAX_BYTES)
    ) u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_item  (r_in),
        .o_res   (step_res)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= step_res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_bus_cmd       = r_out.bus_cmd;
    assign o_tx_byte       = r_out.tx_byte;
    assign o_done_res      = r_out.done_res;
    assign o_read_bytes    = r_out.read_bytes;
    assign o_read_count    = r_out.read_count;
    assign o_failed        = r_out.failed;
    assign o_failed_phase  = r_out.failed_phase;
    assign o_failed_status = r_out.failed_status;
    assign o_rejected      = r_out.rejected;

    a_fire_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> r_out_valid)
        else $error("processed item did not reach the result register");

    a_done_fail_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.done_res && r_out.failed))
        else $error("result both done and failed");

    a_fail_abort: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.failed |-> r_out.bus_cmd == CMD_ABORT)
        else $error("failure without abort command");

    a_reject_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.rejected |-> r_out.bus_cmd == CMD_NONE)
        else $error("rejected submit issued a command");

endmodule

[tb/i2c_seq_checker.sv]
`timescale 1ns / 1ps
module i2c_seq_checker #(
    parameter int MAX_BYTES = i2cms_pkg::MAX_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        o_in_stall,
    input  logic        i_req_type,
    input  logic [7:0]  i_slave_addr,
    input  logic [3:0]  i_byte_count,
    input  logic [63:0] i_write_bytes,
    input  logic [7:0]  i_bus_status,
    input  logic [7:0]  i_rx_byte,
    input  logic        o_out_valid,
    input  logic        i_out_stall,
    input  logic [2:0]  o_bus_cmd,
    input  logic [7:0]  o_tx_byte,
    input  logic        o_done_res,
    input  logic [63:0] o_read_bytes,
    input  logic [3:0]  o_read_count,
    input  logic        o_failed,
    input  logic [3:0]  o_failed_phase,
    input  logic [7:0]  o_failed_status,
    input  logic        o_rejected,
    output int          o_fail_count,
    output int          o_pending
);
    import i2cms_pkg::*;

    // Shadow copy of the transfer state.
    logic [3:0] xfer_phase;
    logic [3:0] xfer_index;
    logic [3:0] xfer_len;
    logic [7:0] xfer_addr;
    logic [7:0] xfer_buf [0:7];

    // Bus commands still owed by the block, oldest first.
    t_result owed_cmds [$];
    int      mismatches = 0;

    // Stop the transfer and report the collected bytes.
    task automatic finish_transfer(inout t_result r);
        logic [63:0] acc;
        int          i;
        acc = '0;
        for (i = 0; i < 8; i++) begin
            if (i < int'(xfer_len)) acc[8*i +: 8] = xfer_buf[i];
        end
        r.bus_cmd    = CMD_STOP;
        r.done_res   = 1'b1;
        r.read_bytes = acc;
        r.read_count = xfer_len;
        xfer_phase   = PN_IDLE;
    endtask

    // Issue the next data byte command, or stop once all bytes are done.
    task automatic next_byte(inout t_result r, input logic is_read);
        if (xfer_index >= xfer_len || int'(xfer_index) >= MAX_BYTES) begin
            finish_transfer(r);
        end else if (is_read) begin
            r.bus_cmd  = (xfer_index + 4'd1 == xfer_len) ? CMD_RX_NACK : CMD_RX_ACK;
            xfer_phase = PN_RD_DATA_WAIT;
        end else begin
            r.bus_cmd  = CMD_SEND;
            r.tx_byte  = xfer_buf[xfer_index[2:0]];
            xfer_phase = PN_WR_DATA_WAIT;
        end
    endtask

    // Advance the transfer by one item and give the command it causes.
    task automatic step_transfer(input t_in_item it, output t_result r);
        logic [7:0] st;
        logic [7:0] want;
        logic       have_want;
        logic [3:0] cnt;
        int         i;
        r         = '0;
        st        = it.bus_status & ST_MASK;
        want      = '0;
        have_want = 1'b1;
        if (it.req_type == REQ_SUBMIT) begin
            if (xfer_phase != PN_IDLE) begin
                r.rejected = 1'b1;
            end else begin
                cnt = (int'(it.byte_count) > MAX_BYTES) ? 4'(MAX_BYTES) : it.byte_count;
                xfer_addr  = it.slave_addr;
                xfer_len   = cnt;
                xfer_index = '0;
                for (i = 0; i < 8; i++) xfer_buf[i] = it.write_bytes[8*i +: 8];
                xfer_phase = PN_START_WAIT;
                r.bus_cmd  = CMD_START;
            end
        end else begin
            case (xfer_phase)
                PN_START_WAIT:   want = ST_START_SENT;
                PN_WR_ADDR_WAIT: want = ST_WR_ADDR_ACK;
                PN_WR_DATA_WAIT: want = ST_WR_DATA_ACK;
                PN_RD_ADDR_WAIT: want = ST_RD_ADDR_ACK;
                PN_RD_DATA_WAIT: begin
                    want = (xfer_index + 4'd1 == xfer_len) ? ST_RD_DATA_NAK : ST_RD_DATA_ACK;
                end
                default:         have_want = 1'b0;
            endcase
            if (!have_want || st != want) begin
                // Any status other than the one awaited aborts the transfer.
                r.bus_cmd       = CMD_ABORT;
                r.failed        = 1'b1;
                r.failed_phase  = xfer_phase;
                r.failed_status = st;
                xfer_phase      = PN_IDLE;
            end else begin
                case (xfer_phase)
                    PN_START_WAIT: begin
                        r.bus_cmd  = CMD_SEND;
                        r.tx_byte  = xfer_addr;
                        xfer_phase = xfer_addr[0] ? PN_RD_ADDR_WAIT : PN_WR_ADDR_WAIT;
                    end
                    PN_WR_ADDR_WAIT: begin
                        xfer_index = '0;
                        next_byte(r, 1'b0);
                    end
                    PN_WR_DATA_WAIT: begin
                        xfer_index = xfer_index + 4'd1;
                        next_byte(r, 1'b0);
                    end
                    PN_RD_ADDR_WAIT: begin
                        xfer_index = '0;
                        next_byte(r, 1'b1);
                    end
                    default: begin
                        if (int'(xfer_index) < MAX_BYTES) xfer_buf[xfer_index[2:0]] = it.rx_byte;
                        xfer_index = xfer_index + 4'd1;
                        next_byte(r, 1'b1);
                    end
                endcase
            end
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] got_v);
        if (exp_v !== got_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
            mismatches++;
        end
    endtask

    // Watch both channels: compare results first, then predict new items.
    always @(posedge i_clk) begin : watch
        t_in_item it;
        t_result  exp_r;
        t_result  got_r;
        if (!i_rst_n) begin
            xfer_phase = PN_IDLE;
            xfer_index = '0;
            xfer_len   = '0;
            xfer_addr  = '0;
            owed_cmds.delete();
            o_pending    <= 0;
            o_fail_count <= 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                got_r.bus_cmd       = t_cmd'(o_bus_cmd);
                got_r.tx_byte       = o_tx_byte;
                got_r.done_res      = o_done_res;
                got_r.read_bytes    = o_read_bytes;
                got_r.read_count    = o_read_count;
                got_r.failed        = o_failed;
                got_r.failed_phase  = o_failed_phase;
                got_r.failed_status = o_failed_status;
                got_r.rejected      = o_rejected;
                if (owed_cmds.size() == 0) begin
                    $error("result arrived with no item outstanding");
                    mismatches++;
                end else begin
                    exp_r = owed_cmds.pop_front();
                    check_field("bus_cmd", 64'(exp_r.bus_cmd), 64'(got_r.bus_cmd));
                    check_field("tx_byte", 64'(exp_r.tx_byte), 64'(got_r.tx_byte));
                    check_field("done_res", 64'(exp_r.done_res), 64'(got_r.done_res));
                    check_field("read_bytes", exp_r.read_bytes, got_r.read_bytes);
                    check_field("read_count", 64'(exp_r.read_count), 64'(got_r.read_count));
                    check_field("failed", 64'(exp_r.failed), 64'(got_r.failed));
                    check_field("failed_phase", 64'(exp_r.failed_phase),
                                64'(got_r.failed_phase));
                    check_field("failed_status", 64'(exp_r.failed_status),
                                64'(got_r.failed_status));
                    check_field("rejected", 64'(exp_r.rejected), 64'(got_r.rejected));
                end
            end
            if (i_in_valid && !o_in_stall) begin
                it.req_type    = i_req_type;
                it.slave_addr  = i_slave_addr;
                it.byte_count  = i_byte_count;
                it.write_bytes = i_write_bytes;
                it.bus_status  = i_bus_status;
                it.rx_byte     = i_rx_byte;
                step_transfer(it, exp_r);
                owed_cmds.push_back(exp_r);
            end
            o_pending    <= owed_cmds.size();
            o_fail_count <= mismatches;
        end
    end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
    import i2cms_pkg::*;

    localparam int ITEM_TARGET  = 1600;
    localparam int HOLD_FROM    = 400;
    localparam int CALM_FROM    = 1400;
    localparam int HOLD_CYCLES  = 200;
    localparam int STUCK_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 10;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_in_valid    = 1'b0;
    logic        o_in_stall;
    logic        i_req_type    = 1'b0;
    logic [7:0]  i_slave_addr  = '0;
    logic [3:0]  i_byte_count  = '0;
    logic [63:0] i_write_bytes = '0;
    logic [7:0]  i_bus_status  = '0;
    logic [7:0]  i_rx_byte     = '0;
    logic        o_out_valid;
    logic        i_out_stall   = 1'b0;
    logic [2:0]  o_bus_cmd;
    logic [7:0]  o_tx_byte;
    logic        o_done_res;
    logic [63:0] o_read_bytes;
    logic [3:0]  o_read_count;
    logic        o_failed;
    logic [3:0]  o_failed_phase;
    logic [7:0]  o_failed_status;
    logic        o_rejected;

    int   fail_count;
    int   results_pending;
    int   items_sent   = 0;
    int   stuck_cycles = 0;
    logic calm         = 1'b0;
    logic hold_req     = 1'b0;
    logic hold_done    = 1'b0;

    i2c_master_transaction_sequencer_top DUT (.*);

    i2c_seq_checker u_checker (
        .*,
        .o_fail_count (fail_count),
        .o_pending    (results_pending)
    );

    always #2 i_clk = ~i_clk;

    // Offer one item and hold it until the block takes it; sometimes pause after.
    task automatic offer_item(input logic rt, input logic [7:0] addr, input logic [3:0] cnt,
                              input logic [63:0] wdata, input logic [7:0] st,
                              input logic [7:0] rx);
        i_in_valid    <= 1'b1;
        i_req_type    <= rt;
        i_slave_addr  <= addr;
        i_byte_count  <= cnt;
        i_write_bytes <= wdata;
        i_bus_status  <= st;
        i_rx_byte     <= rx;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        items_sent++;
        if (!calm && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
    endtask

    task automatic submit(input logic [7:0] addr, input logic [3:0] cnt,
                          input logic [63:0] wdata);
        offer_item(REQ_SUBMIT, addr, cnt, wdata, 8'($urandom), 8'($urandom));
    endtask

    task automatic bus_event(input logic [7:0] st, input logic [7:0] rx);
        offer_item(REQ_EVENT, 8'($urandom), 4'($urandom), {$urandom, $urandom}, st, rx);
    endtask

    // One transfer with random content; now and then a busy submit or a bad status.
    task automatic random_transfer();
        logic [7:0] addr;
        logic [3:0] cnt;
        logic [7:0] want;
        logic [7:0] st;
        int         len;
        int         step;
        logic       broken;
        addr   = 8'($urandom);
        cnt    = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15))
                                             : 4'($urandom_range(0, 8));
        len    = (cnt > 4'd8) ? 8 : int'(cnt);
        broken = 1'b0;
        submit(addr, cnt, {$urandom, $urandom});
        for (step = 0; step < len + 2 && !broken; step++) begin
            if (step == 0)
                want = ST_START_SENT;
            else if (step == 1)
                want = addr[0] ? ST_RD_ADDR_ACK : ST_WR_ADDR_ACK;
            else if (!addr[0])
                want = ST_WR_DATA_ACK;
            else
                want = (step == len + 1) ? ST_RD_DATA_NAK : ST_RD_DATA_ACK;
            if ($urandom_range(0, 39) == 0) submit(8'($urandom), 4'($urandom),
                                                   {$urandom, $urandom});
            if ($urandom_range(0, 29) == 0) begin
                st = 8'($urandom);
                if ((st & ST_MASK) == want) st = st ^ 8'h08;
                broken = 1'b1;
            end else begin
                st = want | 8'($urandom_range(0, 7));
            end
            bus_event(st, 8'($urandom));
        end
    endtask

    // Watchdog: too long without any handshake ends the run.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Result side: random stall bursts, one long hold-off, quiet stretches.
    initial begin
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end else if (!calm && $urandom_range(0, 15) == 0) begin
                repeat ($urandom_range(10, 40)) @(posedge i_clk);
            end
        end
    end

    // Stimulus and verdict.
    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Status event with no transfer running.
        bus_event(8'hFF, 8'h00);

        // Write of zero bytes: address phase, then stop at once.
        submit(8'h00, 4'd0, 64'h0);
        bus_event(8'h0F, 8'h00);
        bus_event(ST_WR_ADDR_ACK, 8'hFF);

        // One-byte read, with a submit arriving while busy.
        submit(8'hFF, 4'd1, 64'hFFFF_FFFF_FFFF_FFFF);
        submit(8'h00, 4'd8, 64'h0);
        bus_event(ST_START_SENT, 8'h00);
        bus_event(ST_RD_ADDR_ACK | 8'h07, 8'h00);
        bus_event(ST_RD_DATA_NAK | 8'h07, 8'hFF);

        // Count above the maximum is clipped to eight bytes.
        submit(8'hFE, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF);
        bus_event(ST_START_SENT, 8'h00);
        bus_event(ST_WR_ADDR_ACK, 8'h00);
        repeat (8) bus_event(ST_WR_DATA_ACK | 8'h07, 8'h00);

        // Read that sees an ACK code on its last byte and aborts.
        submit(8'h01, 4'd2, 64'h0);
        bus_event(ST_START_SENT, 8'h00);
        bus_event(ST_RD_ADDR_ACK, 8'h00);
        bus_event(ST_RD_DATA_ACK, 8'h00);
        bus_event(ST_RD_DATA_ACK, 8'hA5);

        // Random transfers with occasional stray events.
        while (items_sent < ITEM_TARGET) begin
            if (items_sent >= HOLD_FROM) hold_req = 1'b1;
            if (items_sent >= CALM_FROM) calm = 1'b1;
            if ($urandom_range(0, 9) == 0)
                bus_event(8'($urandom), 8'($urandom));
            else
                random_transfer();
        end

        // Drain what is still owed, then let the pipeline settle.
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (results_pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && results_pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
